// ===== src/cpr_pkg.sv =====
// Package for the clock page replacement block.
// Holds the transaction structs, memory entry layout, register indexes and the
// controller/datapath command and status structs. No dependencies.
package cpr_pkg;

    localparam int PAGE_W      = 22;
    localparam int ADDR_W      = 32;
    localparam int CNT_W32     = 32;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 9;
    localparam int SHIFT_W     = 5;
    localparam int FCOUNT_W    = 9;
    localparam int FRAME_OUT_W = 8;

    localparam logic [SHIFT_W-1:0]  SHIFT_MIN         = 5'd10;
    localparam logic [SHIFT_W-1:0]  PAGE_SHIFT_RESET  = 5'd13;
    localparam logic [FCOUNT_W-1:0] FRAME_COUNT_RESET = 9'd128;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 4'd1;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              is_write;
    } req_t;

    typedef struct packed {
        logic                   fault;
        logic                   dirty_evict;
        logic [FRAME_OUT_W-1:0] frame_index;
        logic [CNT_W32-1:0]     fault_count;
        logic [CNT_W32-1:0]     dirty_count;
    } res_t;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic              ref_bit;
        logic              mod_bit;
    } entry_t;

    typedef struct packed {
        logic load;
        logic search;
        logic miss;
        logic sweep_rd;
        logic sweep_chk;
    } cmd_t;

    typedef struct packed {
        logic match;
        logic search_miss;
        logic free_frame;
        logic ref_set;
    } status_t;

endpackage

// ===== src/cpr_datapath.sv =====
// Datapath of the clock page replacement block: configuration registers,
// frame table memory, search and clock hand counters, fault/dirty totals.
// Depends on cpr_pkg.
module cpr_datapath #(
    parameter int FRAMES = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  cpr_pkg::cmd_t                      cmd,
    output cpr_pkg::status_t                   status,
    input  cpr_pkg::req_t                      request,
    input  logic                               cfg_we,
    input  logic [cpr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cpr_pkg::CFG_DATA_W-1:0]     cfg_data,
    output cpr_pkg::res_t                      result
);

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES + 1);

    logic [cpr_pkg::SHIFT_W-1:0]  page_shift_reg;
    logic [cpr_pkg::FCOUNT_W-1:0] frame_count_reg;
    logic [CNT_W-1:0]             frames_loaded_reg;
    logic [IDX_W-1:0]             clock_hand_reg;
    logic [cpr_pkg::CNT_W32-1:0]  faults_total_reg;
    logic [cpr_pkg::CNT_W32-1:0]  dirty_total_reg;
    logic [CNT_W-1:0]             issue_idx_reg;
    logic                         rd_vld_reg;

    logic [cpr_pkg::PAGE_W-1:0]   page_reg;
    logic                         wr_reg;
    logic [IDX_W-1:0]             cmp_idx_reg;
    logic [IDX_W-1:0]             hand_reg;
    logic [IDX_W-1:0]             slot_reg;
    logic                         fault_reg;
    logic                         dirty_reg;
    cpr_pkg::entry_t              rd_data_reg;

    cpr_pkg::entry_t              mem [FRAMES];

    logic [cpr_pkg::SHIFT_W-1:0]  shift_eff;
    logic [cpr_pkg::PAGE_W-1:0]   page_next;
    logic [CNT_W-1:0]             n_eff;
    logic [CNT_W-1:0]             used;
    logic                         issue;
    logic                         match;
    logic                         free_frame;
    logic [CNT_W-1:0]             hand_inc;
    logic [IDX_W-1:0]             hand_next;
    logic [IDX_W-1:0]             hand_start;
    logic                         rd_en;
    logic [IDX_W-1:0]             rd_addr;
    logic                         wr_en;
    logic [IDX_W-1:0]             wr_addr;
    cpr_pkg::entry_t              wr_data;
    logic [IDX_W+7:0]             slot_wide;

    // effective settings
    assign shift_eff = (page_shift_reg < cpr_pkg::SHIFT_MIN) ? cpr_pkg::SHIFT_MIN
                                                             : page_shift_reg;
    assign page_next = cpr_pkg::PAGE_W'(request.address >> shift_eff);

    always_comb
    begin
        if (frame_count_reg == '0)
            n_eff = CNT_W'(1);
        else if (32'(frame_count_reg) > FRAMES)
            n_eff = CNT_W'(FRAMES);
        else
            n_eff = CNT_W'(frame_count_reg);
    end

    assign used       = (frames_loaded_reg < n_eff) ? frames_loaded_reg : n_eff;
    assign free_frame = frames_loaded_reg < n_eff;
    assign issue      = cmd.search && (issue_idx_reg < used);
    assign match      = rd_vld_reg && (rd_data_reg.page == page_reg);

    assign hand_inc   = CNT_W'(hand_reg) + CNT_W'(1);
    assign hand_next  = (hand_inc >= n_eff) ? '0 : IDX_W'(hand_inc);
    assign hand_start = (CNT_W'(clock_hand_reg) < n_eff) ? clock_hand_reg : '0;

    assign status.match       = match;
    assign status.search_miss = !issue && !match;
    assign status.free_frame  = free_frame;
    assign status.ref_set     = rd_data_reg.ref_bit;

    // memory port control
    assign rd_en   = issue || cmd.sweep_rd;
    assign rd_addr = cmd.sweep_rd ? hand_reg : IDX_W'(issue_idx_reg);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = hand_reg;
        wr_data = '{page: page_reg, ref_bit: 1'b1, mod_bit: wr_reg};
        priority if (cmd.search && match)
        begin
            wr_en   = 1'b1;
            wr_addr = cmp_idx_reg;
            wr_data = '{page: rd_data_reg.page, ref_bit: 1'b1,
                        mod_bit: rd_data_reg.mod_bit | wr_reg};
        end
        else if (cmd.miss && free_frame)
        begin
            wr_en   = 1'b1;
            wr_addr = IDX_W'(frames_loaded_reg);
        end
        else if (cmd.sweep_chk && rd_data_reg.ref_bit)
        begin
            wr_en   = 1'b1;
            wr_data = '{page: rd_data_reg.page, ref_bit: 1'b0,
                        mod_bit: rd_data_reg.mod_bit};
        end
        else if (cmd.sweep_chk)
        begin
            wr_en   = 1'b1;
        end
        else
        begin
            wr_en   = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_shift_reg    <= cpr_pkg::PAGE_SHIFT_RESET;
            frame_count_reg   <= cpr_pkg::FRAME_COUNT_RESET;
            frames_loaded_reg <= '0;
            clock_hand_reg    <= '0;
            faults_total_reg  <= '0;
            dirty_total_reg   <= '0;
            issue_idx_reg     <= '0;
            rd_vld_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == cpr_pkg::CFG_PAGE_SHIFT)
                page_shift_reg <= cfg_data[cpr_pkg::SHIFT_W-1:0];
            if (cfg_we && cfg_index == cpr_pkg::CFG_FRAME_COUNT)
                frame_count_reg <= cfg_data[cpr_pkg::FCOUNT_W-1:0];

            if (cmd.load)
            begin
                issue_idx_reg <= '0;
                rd_vld_reg    <= 1'b0;
            end
            else if (cmd.search)
            begin
                rd_vld_reg <= issue;
                if (issue)
                    issue_idx_reg <= issue_idx_reg + CNT_W'(1);
            end

            if (cmd.miss)
            begin
                if (faults_total_reg != '1)
                    faults_total_reg <= faults_total_reg + 32'd1;
                if (free_frame)
                    frames_loaded_reg <= frames_loaded_reg + CNT_W'(1);
            end

            if (cmd.sweep_chk && !rd_data_reg.ref_bit)
            begin
                clock_hand_reg <= hand_next;
                if (rd_data_reg.mod_bit && dirty_total_reg != '1)
                    dirty_total_reg <= dirty_total_reg + 32'd1;
            end
        end
    end

    // per-transaction payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            page_reg  <= page_next;
            wr_reg    <= request.is_write;
            fault_reg <= 1'b0;
            dirty_reg <= 1'b0;
        end
        if (cmd.search)
        begin
            cmp_idx_reg <= IDX_W'(issue_idx_reg);
            if (match)
                slot_reg <= cmp_idx_reg;
        end
        if (cmd.miss)
        begin
            fault_reg <= 1'b1;
            hand_reg  <= hand_start;
            if (free_frame)
                slot_reg <= IDX_W'(frames_loaded_reg);
        end
        if (cmd.sweep_chk)
        begin
            if (rd_data_reg.ref_bit)
                hand_reg <= hand_next;
            else
            begin
                slot_reg  <= hand_reg;
                dirty_reg <= rd_data_reg.mod_bit;
            end
        end
    end

    assign slot_wide = {8'b0, slot_reg};

    assign result.fault       = fault_reg;
    assign result.dirty_evict = dirty_reg;
    assign result.frame_index = slot_wide[7:0];
    assign result.fault_count = faults_total_reg;
    assign result.dirty_count = dirty_total_reg;

endmodule

// ===== src/cpr_ctrl.sv =====
// Controller state machine of the clock page replacement block.
// Sequences search, fill and clock sweep through commands to cpr_datapath.
// Depends on cpr_pkg.
module cpr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    output logic             result_valid,
    output cpr_pkg::cmd_t    cmd,
    input  cpr_pkg::status_t status
);

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_SEARCH    = 6'b000010,
        ST_MISS      = 6'b000100,
        ST_SWEEP_RD  = 6'b001000,
        ST_SWEEP_CHK = 6'b010000,
        ST_DONE      = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                cmd.search = 1'b1;
                if (status.match)
                    state_next = ST_DONE;
                else if (status.search_miss)
                    state_next = ST_MISS;
            end
            ST_MISS:
            begin
                cmd.miss   = 1'b1;
                state_next = status.free_frame ? ST_DONE : ST_SWEEP_RD;
            end
            ST_SWEEP_RD:
            begin
                cmd.sweep_rd = 1'b1;
                state_next   = ST_SWEEP_CHK;
            end
            ST_SWEEP_CHK:
            begin
                cmd.sweep_chk = 1'b1;
                state_next    = status.ref_set ? ST_SWEEP_RD : ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy         = state_reg != ST_IDLE;
    assign result_valid = state_reg == ST_DONE;

endmodule

// ===== src/clock_page_replacement.sv =====
// Clock page replacement: one result per access, strobed on result_valid for one cycle.
// Hit: the frames in use are searched one a cycle. Miss: the search, then a fill or a clock
// sweep in which the hand visits at most n+1 frames, n being the effective frame count.
// One transaction at a time; busy is high until the strobe cycle ends. No stall on output.
// Reset: counters, fill count and hand cleared, page_shift 13, frame_count 128; frame table
// contents are not cleared, as no frame is read before it is filled.
module clock_page_replacement #(
    parameter int FRAMES = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  cpr_pkg::req_t                  request,
    output logic                           result_valid,
    output cpr_pkg::res_t                  result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cpr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cpr_pkg::CFG_DATA_W-1:0] cfg_data
);

    cpr_pkg::cmd_t    cmd;
    cpr_pkg::status_t status;

    assign cfg_ready = 1'b1;

    cpr_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .result_valid (result_valid),
        .cmd          (cmd),
        .status       (status)
    );

    cpr_datapath #(
        .FRAMES (FRAMES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .request   (request),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

endmodule

// ===== dv/clock_page_replacement_tb.sv =====
// Self-checking testbench for clock_page_replacement: directed accesses, then random
// phases across page shift and frame count settings, predicted by a clock-sweep tracker.
// Depends on cpr_pkg and the clock_page_replacement RTL only.
module clock_page_replacement_tb;

    localparam int FRAMES = 256;
    localparam int PHASES = 10;

    class clock_frame_predictor;
        logic [cpr_pkg::SHIFT_W-1:0]  page_shift;
        logic [cpr_pkg::FCOUNT_W-1:0] frame_count;
        bit [cpr_pkg::PAGE_W-1:0]     frame_page [FRAMES];
        bit                           ref_bits [FRAMES];
        bit                           mod_bits [FRAMES];
        int                           frames_loaded;
        int                           clock_hand;
        bit [cpr_pkg::CNT_W32-1:0]    faults_total;
        bit [cpr_pkg::CNT_W32-1:0]    dirty_total;
        cpr_pkg::res_t                outcomes_due [$];
        int                           mismatches;

        function new();
            page_shift    = cpr_pkg::PAGE_SHIFT_RESET;
            frame_count   = cpr_pkg::FRAME_COUNT_RESET;
            frames_loaded = 0;
            clock_hand    = 0;
            faults_total  = '0;
            dirty_total   = '0;
            mismatches    = 0;
        endfunction

        function int eff_shift();
            return (page_shift < cpr_pkg::SHIFT_MIN) ? int'(cpr_pkg::SHIFT_MIN)
                                                     : int'(page_shift);
        endfunction

        function int eff_frames();
            if (frame_count == '0)
                return 1;
            return (frame_count > FRAMES) ? FRAMES : int'(frame_count);
        endfunction

        function void set_register(logic [cpr_pkg::CFG_IDX_W-1:0] idx,
                                   logic [cpr_pkg::CFG_DATA_W-1:0] data);
            if (idx == cpr_pkg::CFG_PAGE_SHIFT)
                page_shift = data[cpr_pkg::SHIFT_W-1:0];
            else if (idx == cpr_pkg::CFG_FRAME_COUNT)
                frame_count = data;
        endfunction

        function void note_access(cpr_pkg::req_t acc);
            bit [cpr_pkg::PAGE_W-1:0] page;
            int n, used, slot, hand, i;
            bit hit;
            cpr_pkg::res_t want;
            page = cpr_pkg::PAGE_W'(acc.address >> eff_shift());
            n    = eff_frames();
            used = (frames_loaded < n) ? frames_loaded : n;
            hit  = 1'b0;
            slot = 0;
            want = '0;
            for (i = 0; i < used; i++)
            begin
                if (!hit && frame_page[i] == page)
                begin
                    hit  = 1'b1;
                    slot = i;
                end
            end
            if (hit)
            begin
                ref_bits[slot] = 1'b1;
                if (acc.is_write)
                    mod_bits[slot] = 1'b1;
            end
            else
            begin
                want.fault = 1'b1;
                if (faults_total != '1)
                    faults_total++;
                if (frames_loaded < n)
                begin
                    slot = frames_loaded;
                    frames_loaded++;
                end
                else
                begin
                    // first lap clears every set bit, so this always ends
                    hand = (clock_hand < n) ? clock_hand : 0;
                    while (ref_bits[hand])
                    begin
                        ref_bits[hand] = 1'b0;
                        hand = (hand + 1 >= n) ? 0 : hand + 1;
                    end
                    slot = hand;
                    if (mod_bits[slot])
                    begin
                        want.dirty_evict = 1'b1;
                        if (dirty_total != '1)
                            dirty_total++;
                    end
                    clock_hand = (hand + 1 >= n) ? 0 : hand + 1;
                end
                frame_page[slot] = page;
                ref_bits[slot]   = 1'b1;
                mod_bits[slot]   = acc.is_write;
            end
            want.frame_index = cpr_pkg::FRAME_OUT_W'(slot);
            want.fault_count = faults_total;
            want.dirty_count = dirty_total;
            outcomes_due.push_back(want);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        task check_outcome(cpr_pkg::res_t got);
            cpr_pkg::res_t want;
            if (outcomes_due.size() == 0)
            begin
                report_mismatch("result strobed with no access outstanding");
                return;
            end
            want = outcomes_due.pop_front();
            if (got.fault !== want.fault)
                report_mismatch($sformatf("fault %0b, expected %0b", got.fault, want.fault));
            if (got.dirty_evict !== want.dirty_evict)
                report_mismatch($sformatf("dirty_evict %0b, expected %0b",
                                          got.dirty_evict, want.dirty_evict));
            if (got.frame_index !== want.frame_index)
                report_mismatch($sformatf("frame_index %0d, expected %0d",
                                          got.frame_index, want.frame_index));
            if (got.fault_count !== want.fault_count)
                report_mismatch($sformatf("fault_count %0d, expected %0d",
                                          got.fault_count, want.fault_count));
            if (got.dirty_count !== want.dirty_count)
                report_mismatch($sformatf("dirty_count %0d, expected %0d",
                                          got.dirty_count, want.dirty_count));
        endtask
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    cpr_pkg::req_t                  request;
    logic                           result_valid;
    cpr_pkg::res_t                  result;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [cpr_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [cpr_pkg::CFG_DATA_W-1:0] cfg_data;

    clock_frame_predictor sb;
    bit [31:0]            page_base;

    clock_page_replacement #(
        .FRAMES(FRAMES)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .result_valid(result_valid),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_outcome(result);
    end

    function automatic cpr_pkg::req_t mk(bit [31:0] addr, bit wr);
        cpr_pkg::req_t acc;
        acc.address  = addr;
        acc.is_write = wr;
        return acc;
    endfunction

    // Early items of a phase walk fresh pages in order to fill the table; later ones
    // draw from a working set larger than the frame count, with some pure noise.
    function automatic cpr_pkg::req_t pick_access(int j);
        cpr_pkg::req_t acc;
        int sh, n, idx;
        bit [31:0] page;
        sh = sb.eff_shift();
        n  = sb.eff_frames();
        if ($urandom_range(0, 9) == 0)
        begin
            acc.address  = $urandom;
            acc.is_write = 1'($urandom);
            return acc;
        end
        idx  = (j < n) ? j : $urandom_range(0, n + n / 2 + 1);
        page = page_base + 32'(idx);
        acc.address  = (page << sh) | ($urandom & ((32'd1 << sh) - 32'd1));
        acc.is_write = ($urandom_range(0, 2) == 0);
        return acc;
    endfunction

    // start is left high on return; the caller lowers it or presents the next access
    task automatic send_access(cpr_pkg::req_t acc);
        start   <= 1'b1;
        request <= acc;
        do
            @(posedge clk);
        while (busy);
        sb.note_access(acc);
    endtask

    task automatic pause_sender(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.outcomes_due.size() != 0);
    endtask

    task automatic write_reg(logic [cpr_pkg::CFG_IDX_W-1:0] idx,
                             logic [cpr_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_register(idx, data);
    endtask

    task automatic reconfigure(logic [cpr_pkg::CFG_DATA_W-1:0] shift_data,
                               logic [cpr_pkg::CFG_DATA_W-1:0] count_data);
        wait_idle();
        write_reg(cpr_pkg::CFG_PAGE_SHIFT, shift_data);
        write_reg(cpr_pkg::CFG_FRAME_COUNT, count_data);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(int shift, int count, int items, bit quiet);
        int j;
        reconfigure({4'($urandom), 5'(shift)}, 9'(count));
        page_base = $urandom;
        for (j = 0; j < items; j++)
        begin
            if (!quiet && $urandom_range(0, 3) == 0)
                pause_sender($urandom_range(1, 6));
            else if (!quiet && $urandom_range(0, 49) == 0)
                wait_idle();
            send_access(pick_access(j));
        end
    endtask

    initial
    begin
        int phase_shift [PHASES];
        int phase_count [PHASES];
        int phase_items [PHASES];
        int p;
        phase_shift = '{10, 31,  0, 16, 21, 13, 11,  12, 20,  10};
        phase_count = '{ 3,  1,  8,  4, 16,  0, 40, 256,  6, 511};
        phase_items = '{45, 25, 45, 30, 50, 20, 60, 300, 35,  30};
        sb        = new();
        rst_n     = 1'b0;
        start     = 1'b0;
        request   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: fill two frames, then hit both, one as a write
        send_access(mk(32'h0000_0000, 1'b0));
        send_access(mk(32'hFFFF_FFFF, 1'b1));
        send_access(mk(32'h0000_1FFF, 1'b1));
        send_access(mk(32'hFFFF_E000, 1'b0));

        // shift below minimum, count lowered to a full table: sweeps and dirty evictions
        reconfigure(9'd5, 9'd2);
        send_access(mk(32'd5 << 10, 1'b0));
        send_access(mk(32'd6 << 10, 1'b1));
        send_access(mk((32'd5 << 10) | 32'h3FF, 1'b1));
        send_access(mk(32'd7 << 10, 1'b0));
        send_access(mk(32'd6 << 10, 1'b0));
        send_access(mk(32'd8 << 10, 1'b0));

        // zero frame count acts as one frame
        reconfigure(9'd5, 9'd0);
        send_access(mk(32'h3000_0000, 1'b1));
        send_access(mk(32'h3000_0004, 1'b0));
        send_access(mk(32'h0000_0000, 1'b0));

        // largest shift, count above the frame limit
        reconfigure(9'd31, 9'h1FF);
        send_access(mk(32'h8000_0000, 1'b1));
        send_access(mk(32'h7FFF_FFFF, 1'b0));
        send_access(mk(32'h8000_0001, 1'b0));

        // upper data bits of the shift register are dropped
        reconfigure(9'h1F4, 9'd256);
        send_access(mk(32'hFFF0_0000, 1'b0));
        send_access(mk(32'h000F_FFFF, 1'b1));
        reconfigure(9'h115, 9'd256);
        send_access(mk(32'hFFE0_0000, 1'b1));

        for (p = 0; p < PHASES; p++)
            run_phase(phase_shift[p], phase_count[p], phase_items[p], p >= PHASES - 2);

        wait_idle();
        repeat (8) @(posedge clk);
        if (sb.outcomes_due.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.outcomes_due.size()));
        if (sb.mismatches == 0)
            $display("clock_page_replacement test passed");
        else
            $display("clock_page_replacement test failed");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("TIMEOUT: run did not complete");
        $display("clock_page_replacement test failed");
        $finish;
    end

endmodule
